// File: rtl/assert_macros.svh
// Assertion macros for the files that carry concurrent checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define AST_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Condition that must hold on every rising edge outside reset.
`define AST_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

// File: rtl/smrm_pkg.sv
// Constants, item codes and the queue item type of the sparse row multiplier.
// No dependencies.
package smrm_pkg;

  localparam int INNER_ROWS    = 256;
  localparam int STORE_ENTRIES = 1024;
  localparam int MAX_COLUMNS   = 64;
  localparam int QUEUE_DEPTH   = 4;

  localparam int ROW_W  = $clog2(INNER_ROWS);
  localparam int PTR_W  = $clog2(STORE_ENTRIES);
  localparam int CNT_W  = PTR_W + 1;
  localparam int COL_W  = 6;
  localparam int NCOL_W = 7;
  localparam int SUM_AW = $clog2(MAX_COLUMNS);
  localparam int QP_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = QP_W + 1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic              hit;
    logic [PTR_W-1:0]  first;
    logic [PTR_W-1:0]  last_p;
    logic [PTR_W-1:0]  slot;
    logic [COL_W-1:0]  col;
    logic signed [31:0] value;
    logic              row_end;
  } desc_t;

endpackage

// File: rtl/sparse_matrix_row_multiply_top.sv
// Top level of the sparse row multiplier: front end, queue and back end.
// Depends on smrm_pkg, smrm_front, smrm_fifo, smrm_back, assert_macros.svh.
//
// Items enter on start while busy is low; results leave one per cycle on
// result_valid and cannot be held off. A load, clear or non-final row entry
// without a right row gives no result. A row entry walks its right row
// through store read, then multiply and accumulate into the column sum
// memory for each stored nonzero, after queue and dispatch. A row end
// scans num_columns sums at one per cycle. The queue takes up to three
// items, so the front end keeps taking items while the back end works.
`include "assert_macros.svh"

module sparse_matrix_row_multiply_top import smrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [7:0]         inner_index,
  input  logic [5:0]         out_col_in,
  input  logic signed [31:0] entry_value,
  input  logic               last_of_row,
  input  logic               num_columns_we,
  input  logic [6:0]         num_columns,
  output logic               result_valid,
  output logic [5:0]         out_column,
  output logic signed [63:0] out_value,
  output logic               row_empty,
  output logic               last
);

  logic [NCOL_W-1:0] num_columns_r;
  logic [NCOL_W-1:0] ncols;
  logic              accept;
  logic              push;
  desc_t             push_data;
  desc_t             head;
  logic              empty;
  logic              pop;
  logic [QC_W-1:0]   count;
  logic [QC_W:0]     occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns_r <= NCOL_W'(MAX_COLUMNS);
    end else if (num_columns_we) begin
      num_columns_r <= num_columns;
    end
  end

  assign ncols     = (num_columns_r > NCOL_W'(MAX_COLUMNS)) ? NCOL_W'(MAX_COLUMNS)
                                                            : num_columns_r;
  assign occupancy = {1'b0, count} + {{QC_W{1'b0}}, push};
  assign busy      = (occupancy >= (QC_W + 1)'(QUEUE_DEPTH - 1));
  assign accept    = start && !busy;

  smrm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .inner_index (inner_index),
    .out_col_in  (out_col_in),
    .entry_value (entry_value),
    .last_of_row (last_of_row),
    .push        (push),
    .push_data   (push_data)
  );

  smrm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (count)
  );

  smrm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .ncols        (ncols),
    .result_valid (result_valid),
    .out_column   (out_column),
    .out_value    (out_value),
    .row_empty    (row_empty),
    .last         (last)
  );

  `AST_ALWAYS(a_queue_bound, clk, rst, occupancy <= (QC_W + 1)'(QUEUE_DEPTH))
  `AST_IMPLIES(a_empty_is_last, clk, rst, result_valid && row_empty, last && out_value == 0)
  `AST_IMPLIES(a_value_nonzero, clk, rst, result_valid && !row_empty, out_value != 0)
  `AST_IMPLIES(a_no_pop_empty, clk, rst, pop, !empty)

endmodule

// File: rtl/smrm_fifo.sv
// Short queue of classified items between front and back.
// Depends on smrm_pkg.
module smrm_fifo import smrm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  desc_t         push_data,
  input  logic          pop,
  output desc_t         head,
  output logic          empty,
  output logic [QC_W-1:0] count
);

  desc_t           mem [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/smrm_front.sv
// Front end: accepts items, keeps the row index of the right store and
// queues classified items bar clears, full loads. Depends on smrm_pkg.
module smrm_front import smrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         kind,
  input  logic [ROW_W-1:0]   inner_index,
  input  logic [COL_W-1:0]   out_col_in,
  input  logic signed [31:0] entry_value,
  input  logic               last_of_row,
  output logic               push,
  output desc_t              push_data
);

  logic [PTR_W-1:0]  row_first [INNER_ROWS];
  logic [PTR_W-1:0]  row_last  [INNER_ROWS];
  logic              row_valid [INNER_ROWS];
  logic [CNT_W-1:0]  stored_count;
  logic [ROW_W-1:0]  last_row;
  logic              last_row_valid;

  logic              stage_valid;
  logic [1:0]        st_kind;
  logic [COL_W-1:0]  st_col;
  logic signed [31:0] st_value;
  logic              st_row_end;
  logic              st_hit;
  logic              st_load_ok;
  logic [PTR_W-1:0]  st_slot;
  logic [PTR_W-1:0]  first_q;
  logic [PTR_W-1:0]  last_q;

  logic load_ok;
  logic new_group;

  assign load_ok   = accept && (kind == KIND_LOAD) && !stored_count[CNT_W-1];
  assign new_group = !last_row_valid || (last_row != inner_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      stored_count   <= '0;
      last_row_valid <= 1'b0;
      last_row       <= '0;
      for (int i = 0; i < INNER_ROWS; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else begin
      stage_valid <= accept;
      if (accept && (kind == KIND_CLEAR)) begin
        stored_count   <= '0;
        last_row_valid <= 1'b0;
        for (int i = 0; i < INNER_ROWS; i++) begin
          row_valid[i] <= 1'b0;
        end
      end else if (load_ok) begin
        stored_count <= stored_count + 1'b1;
        if (new_group) begin
          row_valid[inner_index] <= 1'b1;
          last_row               <= inner_index;
          last_row_valid         <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && new_group) begin
      row_first[inner_index] <= stored_count[PTR_W-1:0];
    end
    if (load_ok) begin
      row_last[inner_index] <= stored_count[PTR_W-1:0];
    end
    first_q    <= row_first[inner_index];
    last_q     <= row_last[inner_index];
    st_hit     <= row_valid[inner_index];
    st_kind    <= kind;
    st_col     <= out_col_in;
    st_value   <= entry_value;
    st_row_end <= last_of_row;
    st_load_ok <= load_ok;
    st_slot    <= stored_count[PTR_W-1:0];
  end

  assign push = stage_valid && (st_kind != KIND_CLEAR) &&
                ((st_kind != KIND_LOAD) || st_load_ok);

  always_comb begin
    push_data.kind    = st_kind;
    push_data.hit     = st_hit;
    push_data.first   = first_q;
    push_data.last_p  = last_q;
    push_data.slot    = st_slot;
    push_data.col     = st_col;
    push_data.value   = st_value;
    push_data.row_end = st_row_end;
  end

endmodule

// File: rtl/smrm_back.sv
// Back end: writes the right store, walks right rows, accumulates column
// sums and scans them out at row end. Depends on smrm_pkg.
module smrm_back import smrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  desc_t              head,
  input  logic               empty,
  output logic               pop,
  input  logic [NCOL_W-1:0]  ncols,
  output logic               result_valid,
  output logic [COL_W-1:0]   out_column,
  output logic signed [63:0] out_value,
  output logic               row_empty,
  output logic               last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state;

  logic [COL_W-1:0]   store_col [STORE_ENTRIES];
  logic signed [31:0] store_val [STORE_ENTRIES];
  logic [COL_W-1:0]   sq_col;
  logic signed [31:0] sq_val;

  logic signed [63:0] sums [MAX_COLUMNS];
  logic               sum_valid [MAX_COLUMNS];
  logic signed [63:0] sum_q;
  logic [SUM_AW-1:0]  sum_addr;
  logic               sum_we;
  logic signed [63:0] sum_wdata;

  logic [PTR_W-1:0]   p;
  logic [PTR_W-1:0]   p_last;
  logic signed [31:0] d_value;
  logic               d_row_end;
  logic               at_end;
  logic signed [63:0] prod;
  logic [SUM_AW-1:0]  col_r;
  logic               col_use;

  logic [NCOL_W-1:0]  j;
  logic               d1;
  logic [SUM_AW-1:0]  jd;
  logic               pend_valid;
  logic [COL_W-1:0]   pend_col;
  logic signed [63:0] pend_value;

  logic signed [63:0] old_sum;
  logic signed [64:0] wide_sum;
  logic signed [63:0] scan_val;

  assign pop = (state == ST_IDLE) && !empty;

  always_comb begin
    sum_addr = (state == ST_SCAN) ? j[SUM_AW-1:0] : sq_col[SUM_AW-1:0];
    old_sum  = sum_valid[col_r] ? sum_q : 64'sd0;
    wide_sum = {old_sum[63], old_sum} + {prod[63], prod};
    if (wide_sum[64] != wide_sum[63]) begin
      sum_wdata = wide_sum[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      sum_wdata = wide_sum[63:0];
    end
    sum_we   = (state == ST_ACC) && col_use;
    scan_val = sum_valid[jd] ? sum_q : 64'sd0;
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind == KIND_LOAD)) begin
      store_col[head.slot] <= head.col;
      store_val[head.slot] <= head.value;
    end
    sq_col <= store_col[p];
    sq_val <= store_val[p];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sums[col_r] <= sum_wdata;
    end
    sum_q <= sums[sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      d1           <= 1'b0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        sum_valid[i] <= 1'b0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            d_value   <= head.value;
            d_row_end <= head.row_end;
            p         <= head.first;
            p_last    <= head.last_p;
            if (head.kind == KIND_EMPTY) begin
              result_valid <= 1'b1;
              out_column   <= '0;
              out_value    <= '0;
              row_empty    <= 1'b1;
              last         <= 1'b1;
            end else if (head.kind == KIND_ROW) begin
              if (head.hit) begin
                state <= ST_RD;
              end else if (head.row_end) begin
                j     <= '0;
                d1    <= 1'b0;
                state <= (ncols == '0) ? ST_FIN : ST_SCAN;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod    <= 64'(d_value * sq_val);
          col_r   <= sq_col[SUM_AW-1:0];
          col_use <= ({1'b0, sq_col} < ncols);
          at_end  <= (p == p_last);
          p       <= p + 1'b1;
          state   <= ST_ACC;
        end
        ST_ACC: begin
          if (col_use) begin
            sum_valid[col_r] <= 1'b1;
          end
          if (!at_end) begin
            state <= ST_MUL;
          end else if (d_row_end) begin
            j     <= '0;
            d1    <= 1'b0;
            state <= (ncols == '0) ? ST_FIN : ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (j < ncols) begin
            j  <= j + 1'b1;
            d1 <= 1'b1;
            jd <= j[SUM_AW-1:0];
          end else begin
            d1 <= 1'b0;
            if (!d1) begin
              state <= ST_FIN;
            end
          end
          if (d1 && (scan_val != 64'sd0)) begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              out_column   <= pend_col;
              out_value    <= pend_value;
              row_empty    <= 1'b0;
              last         <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_col   <= COL_W'(jd);
            pend_value <= scan_val;
          end
        end
        ST_FIN: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          row_empty    <= !pend_valid;
          out_column   <= pend_valid ? pend_col : '0;
          out_value    <= pend_valid ? pend_value : 64'sd0;
          pend_valid   <= 1'b0;
          for (int i = 0; i < MAX_COLUMNS; i++) begin
            sum_valid[i] <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
